// ===== hdl/bcfa_pkg.sv =====
// Shared types and constants for the BCD clock field adjust block.
// Used by bcfa_step and bcd_clock_field_adjust; depends on nothing else.
`timescale 1ns / 1ps

package bcfa_pkg;

   // Field select codes carried in the request tuser.
   typedef enum logic [2:0] {
      OP_HOUR_TENS    = 3'd0,
      OP_HOUR_UNITS   = 3'd1,
      OP_MINUTE_TENS  = 3'd2,
      OP_MINUTE_UNITS = 3'd3,
      OP_DAY          = 3'd4,
      OP_MONTH        = 3'd5,
      OP_CENTURY      = 3'd6,
      OP_YEAR_UNITS   = 3'd7
   } op_type;

   // One time and date, all fields BCD.
   typedef struct packed {
      logic [15:0] year;
      logic [4:0]  month;
      logic [5:0]  day;
      logic [6:0]  minutes;
      logic [5:0]  hours;
   } time_type;

   localparam int unsigned DATA_WIDTH = 40;
   localparam int unsigned OP_WIDTH   = 3;

   localparam logic [5:0]  HOUR_WRAP      = 6'h23;
   localparam logic [5:0]  HOUR_TWENTY    = 6'h20;
   localparam logic [5:0]  HOUR_UNITS_TOP = 6'h22;
   localparam logic [6:0]  MINUTE_TOP     = 7'h50;
   localparam logic [5:0]  FEB_LEAP       = 6'h29;
   localparam logic [5:0]  FEB_PLAIN      = 6'h28;
   localparam logic [5:0]  MONTH_BASE     = 6'h30;
   localparam logic [7:0]  CENTURY_20     = 8'h20;
   localparam logic [7:0]  YEAR_UNITS_TOP = 8'h99;
   localparam logic [4:0]  MONTH_TOP      = 5'h12;
   localparam logic [4:0]  MONTH_SEPT     = 5'h09;
   localparam logic [4:0]  MONTH_OCT      = 5'h10;
   localparam logic [4:0]  MONTH_FEB      = 5'h02;
   localparam logic [3:0]  DIGIT_NINE     = 4'd9;

   // Leap rule: low three digits 000, or last two digits divisible by four
   // but not 00. Ten times the tens digit is 2*tens modulo four.
   function automatic logic leap_year(input logic [15:0] y);
      logic [1:0] rem;
      rem = y[1:0] + {y[4], 1'b0};
      if (y[11:0] == 12'h000)
         return 1'b1;
      return (rem == 2'd0) && (y[7:0] != 8'h00);
   endfunction

   function automatic logic [5:0] month_length(input logic [4:0] m,
                                               input logic [15:0] y);
      if (m == MONTH_FEB)
         return leap_year(y) ? FEB_LEAP : FEB_PLAIN;
      if (m < 5'd8)
         return MONTH_BASE | {5'd0, m[0]};
      return MONTH_BASE | {5'd0, ~m[0]};
   endfunction

endpackage

// ===== hdl/bcd_clock_field_adjust.sv =====
// From request accept to response valid: input register, then result
// register. Throughput: one request per cycle unless rsp_tready stalls,
// set by the single stepper between them; a full pipeline holds two requests.
// Reset: synchronous, active high; clears both stage valid flags, the data
// registers are not reset.
// Top level: input stage register, bcfa_step logic and output register.
// Depends on bcfa_pkg and bcfa_step.
`timescale 1ns / 1ps

module bcd_clock_field_adjust (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: hours[5:0], minutes[12:6], day[18:13], month[23:19], year[39:24]
   input  logic [39:0] req_tdata,
   // tuser: op[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: hours[5:0], minutes[12:6], day[18:13], month[23:19], year[39:24]
   output logic [39:0] rsp_tdata
);

   logic                 a_valid_ff, a_valid_in;
   bcfa_pkg::op_type     a_op_ff;
   bcfa_pkg::time_type   a_time_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   bcfa_pkg::time_type   rsp_time_ff;
   bcfa_pkg::time_type   step_time;
   logic                 b_ready;
   logic                 a_ready;
   logic                 a_move;

   // The output stage frees up when empty or when its response is taken.
   assign b_ready    = !rsp_valid_ff || rsp_tready;
   assign a_move     = a_valid_ff && b_ready;
   assign a_ready    = !a_valid_ff || b_ready;
   assign req_tready = a_ready;

   assign a_valid_in   = (req_tvalid && a_ready) || (a_valid_ff && !b_ready);
   assign rsp_valid_in = a_move || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && a_ready) begin
         a_op_ff   <= bcfa_pkg::op_type'(req_tuser);
         a_time_ff <= req_tdata;
      end
      if (a_move) begin
         rsp_time_ff <= step_time;
      end
   end

   bcfa_step u_step (
      .op  (a_op_ff),
      .cur (a_time_ff),
      .nxt (step_time)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_time_ff;

`ifndef NO_ASSERTIONS
   a_full_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request accepted while both stages were stalled");

   a_move_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      a_move |=> rsp_valid_ff)
      else $error("input stage advanced but no response became valid");

   a_stall_keeps_item: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !b_ready) |=> a_valid_ff)
      else $error("stalled input stage lost its request");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !a_valid_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule

// ===== hdl/bcfa_step.sv =====
// Combinational field stepper: applies the wrap rules of one selected field; a month step also clamps the day.
// Depends on bcfa_pkg for the op codes, time struct and month length.
`timescale 1ns / 1ps

module bcfa_step (
   input  bcfa_pkg::op_type   op,
   input  bcfa_pkg::time_type cur,
   output bcfa_pkg::time_type nxt
);

   always_comb begin
      logic [5:0] len;
      logic [4:0] mo;
      nxt = cur;
      len = 6'd0;
      mo  = cur.month;
      case (op)
         bcfa_pkg::OP_HOUR_TENS: begin
            if (cur.hours >= bcfa_pkg::HOUR_WRAP)
               nxt.hours = 6'd0;
            else if (cur.hours >= bcfa_pkg::HOUR_TWENTY)
               nxt.hours = {2'b00, cur.hours[3:0]};
            else
               nxt.hours = cur.hours + 6'h10;
         end
         bcfa_pkg::OP_HOUR_UNITS: begin
            if (cur.hours >= bcfa_pkg::HOUR_UNITS_TOP ||
                cur.hours[3:0] >= bcfa_pkg::DIGIT_NINE)
               nxt.hours = {cur.hours[5:4], 4'd0};
            else
               nxt.hours = cur.hours + 6'd1;
         end
         bcfa_pkg::OP_MINUTE_TENS: begin
            if (cur.minutes >= bcfa_pkg::MINUTE_TOP)
               nxt.minutes = {3'd0, cur.minutes[3:0]};
            else
               nxt.minutes = cur.minutes + 7'h10;
         end
         bcfa_pkg::OP_MINUTE_UNITS: begin
            if (cur.minutes[3:0] >= bcfa_pkg::DIGIT_NINE)
               nxt.minutes = {cur.minutes[6:4], 4'd0};
            else
               nxt.minutes = cur.minutes + 7'd1;
         end
         bcfa_pkg::OP_DAY: begin
            len = bcfa_pkg::month_length(cur.month, cur.year);
            if (cur.day >= len)
               nxt.day = 6'd1;
            else if (cur.day[3:0] >= bcfa_pkg::DIGIT_NINE)
               nxt.day = cur.day + 6'd7;
            else
               nxt.day = cur.day + 6'd1;
         end
         bcfa_pkg::OP_MONTH: begin
            if (cur.month == bcfa_pkg::MONTH_SEPT)
               mo = bcfa_pkg::MONTH_OCT;
            else if (cur.month >= bcfa_pkg::MONTH_TOP)
               mo = 5'd1;
            else
               mo = cur.month + 5'd1;
            nxt.month = mo;
            // The day is clamped against the length of the new month.
            len = bcfa_pkg::month_length(mo, cur.year);
            if (cur.day >= len)
               nxt.day = len;
         end
         bcfa_pkg::OP_CENTURY: begin
            if (cur.year[15:8] == bcfa_pkg::CENTURY_20)
               nxt.year = cur.year + 16'h0100;
            else
               nxt.year = cur.year - 16'h0100;
         end
         bcfa_pkg::OP_YEAR_UNITS: begin
            if (cur.year[7:0] == bcfa_pkg::YEAR_UNITS_TOP)
               nxt.year = {cur.year[15:8], 8'h00};
            else if (cur.year[3:0] >= bcfa_pkg::DIGIT_NINE)
               nxt.year = cur.year + 16'd7;
            else
               nxt.year = cur.year + 16'd1;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule
